>>> rtl/core/pidw_pkg.sv
`timescale 1ns / 1ps

package pidw_pkg;

    // Microcode step counter
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] STEP_IDLE = 4'd0;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDUP_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN  = 3'd4;

    typedef enum logic [1:0] {
        A_ERR,
        A_DERR,
        A_SUM
    } mul_a_t;

    typedef enum logic [1:0] {
        B_PROP,
        B_INTEG,
        B_DERIV,
        B_OUT
    } mul_b_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_PROD,
        ACC_ADD_INTEG,
        ACC_ADD_SP,
        ACC_CLAMP
    } acc_op_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_WAIT_IN,
        J_WAIT_OUT
    } jmp_t;

    typedef struct packed {
        mul_a_t            a_sel;
        mul_b_t            b_sel;
        logic              mul_en;
        acc_op_t           acc_op;
        logic              int_en;
        logic              last_en;
        logic              out_en;
        jmp_t              jmp;
        logic [PC_W-1:0]   target;
    } uword_t;

    typedef struct packed {
        mul_a_t  a_sel;
        mul_b_t  b_sel;
        logic    mul_en;
        acc_op_t acc_op;
        logic    int_en;
        logic    last_en;
        logic    load_in;
        logic    load_out;
    } dp_ctrl_t;

    // Control store. One step per cycle unless waiting for input at step 0 or
    // for the output at step 9; the step after a multiply consumes its result.
    function automatic uword_t pidw_ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '0;
        w.a_sel  = A_ERR;
        w.b_sel  = B_PROP;
        w.acc_op = ACC_HOLD;
        w.jmp    = J_NEXT;
        w.target = STEP_IDLE;
        case (pc)
            4'd0:
            begin
                w.jmp = J_WAIT_IN;
            end
            4'd1:
            begin
                w.a_sel  = A_ERR;
                w.b_sel  = B_PROP;
                w.mul_en = 1'b1;
            end
            4'd2:
            begin
                w.a_sel  = A_ERR;
                w.b_sel  = B_INTEG;
                w.mul_en = 1'b1;
                w.acc_op = ACC_LOAD;
            end
            4'd3:
            begin
                w.a_sel   = A_DERR;
                w.b_sel   = B_DERIV;
                w.mul_en  = 1'b1;
                w.int_en  = 1'b1;
                w.last_en = 1'b1;
            end
            4'd4:
            begin
                w.acc_op = ACC_ADD_PROD;
            end
            4'd5:
            begin
                w.acc_op = ACC_ADD_INTEG;
            end
            4'd6:
            begin
                w.acc_op = ACC_ADD_SP;
            end
            4'd7:
            begin
                w.acc_op = ACC_CLAMP;
            end
            4'd8:
            begin
                w.a_sel  = A_SUM;
                w.b_sel  = B_OUT;
                w.mul_en = 1'b1;
            end
            4'd9:
            begin
                w.out_en = 1'b1;
                w.jmp    = J_WAIT_OUT;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.jmp    = J_WAIT_OUT;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/pid_controller_windup_ff.sv
`timescale 1ns / 1ps

// PID controller with integrator anti-windup and setpoint feed-forward.
// Each beat on the input channel (setpoint, measured) yields one drive beat
// equal to (P + I + D + setpoint) * output_gain, saturated to DATA_WIDTH
// signed bits. A ten-step microcode program runs every sample through one
// shared multiplier. A sample is accepted only at the idle step, so none is
// taken until the last result has reached the output register. If that beat
// is still waiting there, the next sample holds at the last step until it is
// taken, and the acceptance after it slips by the remaining stall. Gains and
// the windup limit are written through cfg_we/cfg_index/cfg_data while the
// block is idle; the user must keep to that, as the block does not enforce
// it. output_gain resets to 1, everything else to 0.

module pid_controller_windup_ff
    import pidw_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [DATA_WIDTH-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] setpoint,
    input  logic signed [DATA_WIDTH-1:0] measured,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] drive
);

    localparam int W = DATA_WIDTH;

    logic signed [W-1:0] prop_gain_reg;
    logic signed [W-1:0] integ_gain_reg;
    logic signed [W-1:0] deriv_gain_reg;
    logic        [W-2:0] windup_limit_reg;
    logic signed [W-1:0] output_gain_reg;
    dp_ctrl_t            ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= '0;
            integ_gain_reg   <= '0;
            deriv_gain_reg   <= '0;
            windup_limit_reg <= '0;
            output_gain_reg  <= {{(W-1){1'b0}}, 1'b1};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PROP_GAIN:    prop_gain_reg    <= cfg_data;
                REG_INTEG_GAIN:   integ_gain_reg   <= cfg_data;
                REG_DERIV_GAIN:   deriv_gain_reg   <= cfg_data;
                REG_WINDUP_LIMIT: windup_limit_reg <= cfg_data[W-2:0];
                REG_OUTPUT_GAIN:  output_gain_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    pidw_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    pidw_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .setpoint     (setpoint),
        .measured     (measured),
        .prop_gain    (prop_gain_reg),
        .integ_gain   (integ_gain_reg),
        .deriv_gain   (deriv_gain_reg),
        .windup_limit (windup_limit_reg),
        .output_gain  (output_gain_reg),
        .drive        (drive)
    );

endmodule

>>> rtl/core/pidw_seq.sv
`timescale 1ns / 1ps

module pidw_seq
    import pidw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_ctrl_t ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    uword_t          uw;
    logic            out_busy;
    logic            in_fire;

    assign uw       = pidw_ucode(pc_reg);
    assign in_ready = (pc_reg == STEP_IDLE);
    assign in_fire  = in_valid && in_ready;
    // output register still holds a beat that is not taken this cycle
    assign out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        case (uw.jmp)
            J_NEXT:     pc_next = pc_reg + {{(PC_W-1){1'b0}}, 1'b1};
            J_WAIT_IN:  pc_next = in_valid ? pc_reg + {{(PC_W-1){1'b0}}, 1'b1} : pc_reg;
            J_WAIT_OUT: pc_next = out_busy ? pc_reg : uw.target;
            default:    pc_next = STEP_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.a_sel    = uw.a_sel;
        ctrl.b_sel    = uw.b_sel;
        ctrl.mul_en   = uw.mul_en;
        ctrl.acc_op   = uw.acc_op;
        ctrl.int_en   = uw.int_en;
        ctrl.last_en  = uw.last_en;
        ctrl.load_in  = in_fire;
        ctrl.load_out = uw.out_en && !out_busy;
    end

    always_comb
    begin
        if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/pidw_dp.sv
`timescale 1ns / 1ps

module pidw_dp
    import pidw_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_ctrl_t                     ctrl,
    input  logic signed [DATA_WIDTH-1:0] setpoint,
    input  logic signed [DATA_WIDTH-1:0] measured,
    input  logic signed [DATA_WIDTH-1:0] prop_gain,
    input  logic signed [DATA_WIDTH-1:0] integ_gain,
    input  logic signed [DATA_WIDTH-1:0] deriv_gain,
    input  logic        [DATA_WIDTH-2:0] windup_limit,
    input  logic signed [DATA_WIDTH-1:0] output_gain,
    output logic signed [DATA_WIDTH-1:0] drive
);

    localparam int W  = DATA_WIDTH;
    localparam int EW = W + 1;      // error, integrator
    localparam int AW = W + 2;      // multiplier A operand
    localparam int PW = AW + W;     // product
    localparam int SW = PW + 3;     // accumulator: three terms plus setpoint

    // gain products are held to +-2^61; below that width they never get there
    localparam logic signed [SW-1:0] PLIM = (PW > 62) ?
        ({{(SW-1){1'b0}}, 1'b1} << 61) : {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] MAXW_S = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] MINW_S = ~MAXW_S;
    localparam logic signed [PW-1:0] MAXW_P = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] MINW_P = ~MAXW_P;

    logic signed [W-1:0]  sp_reg;
    logic signed [EW-1:0] err_reg;
    logic signed [EW-1:0] last_err_reg;
    logic signed [EW-1:0] integ_reg;
    logic signed [EW-1:0] integ_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [SW-1:0] acc_reg;
    logic signed [SW-1:0] acc_next;
    logic signed [W-1:0]  drive_reg;
    logic signed [W-1:0]  drive_next;

    logic signed [EW-1:0] err_in;
    logic signed [AW-1:0] derr;
    logic signed [AW-1:0] mul_a;
    logic signed [W-1:0]  mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [SW-1:0] prod_x;
    logic signed [SW-1:0] prod_sat;
    logic signed [SW-1:0] int_sum;
    logic signed [SW-1:0] lim;
    logic signed [SW-1:0] int_clamped;

    assign err_in = {setpoint[W-1], setpoint} - {measured[W-1], measured};
    assign derr   = {err_reg[EW-1], err_reg} - {last_err_reg[EW-1], last_err_reg};

    always_comb
    begin
        case (ctrl.a_sel)
            A_ERR:   mul_a = {err_reg[EW-1], err_reg};
            A_DERR:  mul_a = derr;
            A_SUM:   mul_a = {{(AW-W){acc_reg[W-1]}}, acc_reg[W-1:0]};
            default: mul_a = '0;
        endcase
    end

    always_comb
    begin
        case (ctrl.b_sel)
            B_PROP:  mul_b = prop_gain;
            B_INTEG: mul_b = integ_gain;
            B_DERIV: mul_b = deriv_gain;
            B_OUT:   mul_b = output_gain;
            default: mul_b = '0;
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign prod_x = {{(SW-PW){prod_reg[PW-1]}}, prod_reg};

    always_comb
    begin
        if (prod_x > PLIM)
        begin
            prod_sat = PLIM;
        end
        else if (prod_x < -PLIM)
        begin
            prod_sat = -PLIM;
        end
        else
        begin
            prod_sat = prod_x;
        end
    end

    // anti-windup clamp
    assign int_sum = {{(SW-EW){integ_reg[EW-1]}}, integ_reg} + prod_sat;
    assign lim     = {{(SW-W+1){1'b0}}, windup_limit};

    always_comb
    begin
        if (int_sum > lim)
        begin
            int_clamped = lim;
        end
        else if (int_sum < -lim)
        begin
            int_clamped = -lim;
        end
        else
        begin
            int_clamped = int_sum;
        end
        integ_next = int_clamped[EW-1:0];
    end

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_HOLD:      acc_next = acc_reg;
            ACC_LOAD:      acc_next = prod_sat;
            ACC_ADD_PROD:  acc_next = acc_reg + prod_sat;
            ACC_ADD_INTEG: acc_next = acc_reg + {{(SW-EW){integ_reg[EW-1]}}, integ_reg};
            ACC_ADD_SP:    acc_next = acc_reg + {{(SW-W){sp_reg[W-1]}}, sp_reg};
            ACC_CLAMP:
            begin
                if (acc_reg > MAXW_S)
                begin
                    acc_next = MAXW_S;
                end
                else if (acc_reg < MINW_S)
                begin
                    acc_next = MINW_S;
                end
                else
                begin
                    acc_next = acc_reg;
                end
            end
            default:       acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        if (prod_reg > MAXW_P)
        begin
            drive_next = MAXW_P[W-1:0];
        end
        else if (prod_reg < MINW_P)
        begin
            drive_next = MINW_P[W-1:0];
        end
        else
        begin
            drive_next = prod_reg[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            last_err_reg <= '0;
        end
        else
        begin
            if (ctrl.int_en)
            begin
                integ_reg <= integ_next;
            end
            if (ctrl.last_en)
            begin
                last_err_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            sp_reg  <= setpoint;
            err_reg <= err_in;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= mul_p;
        end
        acc_reg <= acc_next;
        if (ctrl.load_out)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive = drive_reg;

endmodule

>>> rtl/core/pidw_chk.sv
`timescale 1ns / 1ps

module pidw_chk
#(
    parameter int DATA_WIDTH = 16
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [DATA_WIDTH-1:0] drive
);

    // a held result beat must not change
    a_drive_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(drive)))
        else $error("drive changed while stalled");

    // one sample at a time: accepting a beat closes the input
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // a result needs the whole program; it cannot follow an accept directly
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result appeared right after accept");

    // a fresh result returns the sequencer to the idle step
    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("input not ready after result was produced");

endmodule

bind pid_controller_windup_ff pidw_chk #(.DATA_WIDTH(DATA_WIDTH)) u_pidw_chk (.*);
